@@ hw/rtl/urb_pkg.sv @@
// shared types and constants for the uart ring buffer unit
package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int BYTE_W   = 8;
  localparam int LEVEL_W  = 6;
  localparam int OP_W     = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_READ     = 2'd1,
    OP_WRITE    = 2'd2,
    OP_TX_READY = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              frame_error;
    logic              overrun_error;
    logic              parity_error;
  } in_item_t;

  // result fields that do not come out of a ring memory
  typedef struct packed {
    logic               read_valid;
    logic               write_accepted;
    logic               rx_accepted;
    logic               tx_valid;
    logic               tx_irq_enable;
    logic               clear_tx_done;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } res_t;

endpackage

@@ hw/rtl/urb_ram.sv @@
// generic single-write single-read ram with registered read data
module urb_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/urb_ctrl.sv @@
// ring pointers, interrupt enable, parity setting and per-beat decisions
module urb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           fire,
  input  urb_pkg::in_item_t              item,
  output logic                           rx_we,
  output logic [urb_pkg::RX_PTR_W-1:0]   rx_waddr,
  output logic                           rx_re,
  output logic [urb_pkg::RX_PTR_W-1:0]   rx_raddr,
  output logic                           tx_we,
  output logic [urb_pkg::TX_PTR_W-1:0]   tx_waddr,
  output logic                           tx_re,
  output logic [urb_pkg::TX_PTR_W-1:0]   tx_raddr,
  output urb_pkg::res_t                  res_nxt
);

  logic [urb_pkg::RX_PTR_W-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt, rx_wr_inc;
  logic [urb_pkg::TX_PTR_W-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt, tx_wr_inc;
  logic [urb_pkg::RX_PTR_W-1:0] rx_diff;
  logic [urb_pkg::TX_PTR_W-1:0] tx_diff;
  logic tx_irq_r, tx_irq_nxt;
  logic parity_r;
  logic rx_empty, rx_full, tx_empty, tx_full, drop;

  assign rx_wr_inc = rx_wr_r + urb_pkg::RX_PTR_W'(1);
  assign tx_wr_inc = tx_wr_r + urb_pkg::TX_PTR_W'(1);
  assign rx_empty  = (rx_wr_r == rx_rd_r);
  assign tx_empty  = (tx_wr_r == tx_rd_r);
  assign rx_full   = (rx_wr_inc == rx_rd_r);
  assign tx_full   = (tx_wr_inc == tx_rd_r);
  assign drop      = item.frame_error | item.overrun_error | (parity_r & item.parity_error);

  assign rx_waddr = rx_wr_r;
  assign rx_raddr = rx_rd_r;
  assign tx_waddr = tx_wr_r;
  assign tx_raddr = tx_rd_r;

  always_comb begin
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rx_wr_nxt  = rx_wr_r;
    rx_rd_nxt  = rx_rd_r;
    tx_wr_nxt  = tx_wr_r;
    tx_rd_nxt  = tx_rd_r;
    tx_irq_nxt = tx_irq_r;
    res_nxt    = '0;
    unique case (item.op)
      urb_pkg::OP_RX_BYTE: begin
        if (!drop && !rx_full) begin
          rx_we               = fire;
          rx_wr_nxt           = rx_wr_inc;
          res_nxt.rx_accepted = 1'b1;
        end
      end
      urb_pkg::OP_READ: begin
        if (!rx_empty) begin
          rx_re              = fire;
          rx_rd_nxt          = rx_rd_r + urb_pkg::RX_PTR_W'(1);
          res_nxt.read_valid = 1'b1;
        end
      end
      urb_pkg::OP_WRITE: begin
        if (!tx_full) begin
          tx_we                  = fire;
          tx_wr_nxt              = tx_wr_inc;
          tx_irq_nxt             = 1'b1;
          res_nxt.write_accepted = 1'b1;
          res_nxt.clear_tx_done  = tx_empty;
        end
      end
      urb_pkg::OP_TX_READY: begin
        if (tx_empty) begin
          tx_irq_nxt = 1'b0;
        end else begin
          tx_re            = fire;
          tx_rd_nxt        = tx_rd_r + urb_pkg::TX_PTR_W'(1);
          res_nxt.tx_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rx_diff               = rx_wr_nxt - rx_rd_nxt;
    tx_diff               = tx_wr_nxt - tx_rd_nxt;
    res_nxt.tx_irq_enable = tx_irq_nxt;
    res_nxt.rx_level      = urb_pkg::LEVEL_W'(rx_diff);
    res_nxt.tx_level      = urb_pkg::LEVEL_W'(tx_diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_r  <= '0;
      rx_rd_r  <= '0;
      tx_wr_r  <= '0;
      tx_rd_r  <= '0;
      tx_irq_r <= 1'b0;
    end else if (fire) begin
      rx_wr_r  <= rx_wr_nxt;
      rx_rd_r  <= rx_rd_nxt;
      tx_wr_r  <= tx_wr_nxt;
      tx_rd_r  <= tx_rd_nxt;
      tx_irq_r <= tx_irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (cfg_wr_en) begin
      parity_r <= cfg_wr_data;
    end
  end

  // a push must never land on the slot still waiting to be read
  a_rx_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rx_we |-> (rx_wr_inc != rx_rd_r))
    else $error("rx ring overwrite");

  a_tx_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    tx_we |-> (tx_wr_inc != tx_rd_r))
    else $error("tx ring overwrite");

  a_irq_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && tx_we |=> tx_irq_r)
    else $error("tx irq enable not set after push");

  a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.op == urb_pkg::OP_TX_READY) && tx_empty |=> !tx_irq_r)
    else $error("tx irq enable not cleared on empty ring");

endmodule

@@ hw/rtl/uart_rx_tx_ring_buffers_top.sv @@
// top level of the uart ring buffer unit: stream ports, rings and result register
// One event is taken per beat on the in_ side; every event gives exactly one result
// beat on the out_ side in the cycle after, out of a single result register, so the
// unit sustains one event per clock while out_tready stays high. in_tready stays
// high while the result register is empty or being drained in the same cycle. The
// receive and transmit rings each live in a one-write one-read ram with registered
// read data; each holds at most depth-1 bytes, and a full or empty ring is reported
// through the accept and valid flags rather than by stalling. Levels are the byte
// counts after the event, modulo 64. The parity check setting is written through
// cfg_wr_en and cfg_wr_data and should be changed only while no beat is in flight.
module uart_rx_tx_ring_buffers_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // data[7:0], frame_error[8], overrun_error[9], parity_error[10], zero[15:11]
  input  logic [urb_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op[1:0]
  input  logic [urb_pkg::OP_W-1:0]            in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data[7:0], read_valid[8], write_accepted[9], rx_accepted[10],
  // tx_byte[18:11], tx_valid[19], tx_irq_enable[20], clear_tx_done[21],
  // rx_level[27:22], tx_level[33:28], zero[39:34]
  output logic [urb_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  urb_pkg::in_item_t item;
  urb_pkg::res_t     res_nxt;
  urb_pkg::res_t     res_r;
  logic              fire;
  logic              out_valid_r;

  logic                          rx_we, rx_re, tx_we, tx_re;
  logic [urb_pkg::RX_PTR_W-1:0]  rx_waddr, rx_raddr;
  logic [urb_pkg::TX_PTR_W-1:0]  tx_waddr, tx_raddr;
  logic [urb_pkg::BYTE_W-1:0]    rx_rdata, tx_rdata;
  logic [urb_pkg::BYTE_W-1:0]    read_data, tx_byte;

  assign item.op            = urb_pkg::op_t'(in_tuser);
  assign item.data          = in_tdata[7:0];
  assign item.frame_error   = in_tdata[8];
  assign item.overrun_error = in_tdata[9];
  assign item.parity_error  = in_tdata[10];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  urb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .rx_we       (rx_we),
    .rx_waddr    (rx_waddr),
    .rx_re       (rx_re),
    .rx_raddr    (rx_raddr),
    .tx_we       (tx_we),
    .tx_waddr    (tx_waddr),
    .tx_re       (tx_re),
    .tx_raddr    (tx_raddr),
    .res_nxt     (res_nxt)
  );

  urb_ram #(
    .ADDR_W (urb_pkg::RX_PTR_W),
    .DATA_W (urb_pkg::BYTE_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (item.data),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  urb_ram #(
    .ADDR_W (urb_pkg::TX_PTR_W),
    .DATA_W (urb_pkg::BYTE_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (item.data),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // ram read data only refreshes on a pop, so mask it with the valid flags
  assign read_data = res_r.read_valid ? rx_rdata : '0;
  assign tx_byte   = res_r.tx_valid ? tx_rdata : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.tx_level, res_r.rx_level, res_r.clear_tx_done,
                       res_r.tx_irq_enable, res_r.tx_valid, tx_byte,
                       res_r.rx_accepted, res_r.write_accepted, res_r.read_valid,
                       read_data};

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted beat gave no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result register is blocked");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({res_r.read_valid, res_r.write_accepted,
                              res_r.rx_accepted, res_r.tx_valid}))
    else $error("result flags from more than one event");

endmodule

@@ tb/tb_uart_rx_tx_ring_buffers_top.sv @@
`timescale 1ns / 100ps
// testbench for the uart ring buffer unit: directed and random events checked by a ring predictor
module tb_uart_rx_tx_ring_buffers_top;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [urb_pkg::BYTE_W-1:0]  read_data;
    logic                        read_valid;
    logic                        write_accepted;
    logic                        rx_accepted;
    logic [urb_pkg::BYTE_W-1:0]  tx_byte;
    logic                        tx_valid;
    logic                        tx_irq_enable;
    logic                        clear_tx_done;
    logic [urb_pkg::LEVEL_W-1:0] rx_level;
    logic [urb_pkg::LEVEL_W-1:0] tx_level;
  } ring_result_t;

  class ring_scoreboard;
    logic [urb_pkg::BYTE_W-1:0]   rx_mem [urb_pkg::RX_DEPTH];
    logic [urb_pkg::BYTE_W-1:0]   tx_mem [urb_pkg::TX_DEPTH];
    logic [urb_pkg::RX_PTR_W-1:0] rx_wr;
    logic [urb_pkg::RX_PTR_W-1:0] rx_rd;
    logic [urb_pkg::TX_PTR_W-1:0] tx_wr;
    logic [urb_pkg::TX_PTR_W-1:0] tx_rd;
    logic                         tx_irq;
    logic                         parity_on;
    ring_result_t                 pending_results[$];
    int                           errors;

    function new();
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      tx_irq = 1'b0;
      parity_on = 1'b0;
      errors = 0;
    endfunction

    function ring_result_t ring_step(urb_pkg::in_item_t it);
      ring_result_t                 r;
      logic [urb_pkg::RX_PTR_W-1:0] rx_next;
      logic [urb_pkg::TX_PTR_W-1:0] tx_next;
      r = '{default: '0};
      rx_next = rx_wr + urb_pkg::RX_PTR_W'(1);
      tx_next = tx_wr + urb_pkg::TX_PTR_W'(1);
      case (it.op)
        urb_pkg::OP_RX_BYTE: begin
          if (!(it.frame_error || it.overrun_error || (parity_on && it.parity_error))
              && rx_next != rx_rd) begin
            rx_mem[rx_wr] = it.data;
            rx_wr = rx_next;
            r.rx_accepted = 1'b1;
          end
        end
        urb_pkg::OP_READ: begin
          if (rx_wr != rx_rd) begin
            r.read_data = rx_mem[rx_rd];
            r.read_valid = 1'b1;
            rx_rd = rx_rd + urb_pkg::RX_PTR_W'(1);
          end
        end
        urb_pkg::OP_WRITE: begin
          // one slot stays free, so a full ring rejects the write untouched
          if (tx_next != tx_rd) begin
            r.clear_tx_done = (tx_wr == tx_rd);
            tx_mem[tx_wr] = it.data;
            tx_wr = tx_next;
            tx_irq = 1'b1;
            r.write_accepted = 1'b1;
          end
        end
        default: begin
          if (tx_wr == tx_rd) begin
            tx_irq = 1'b0;
          end else begin
            r.tx_byte = tx_mem[tx_rd];
            r.tx_valid = 1'b1;
            tx_rd = tx_rd + urb_pkg::TX_PTR_W'(1);
          end
        end
      endcase
      r.tx_irq_enable = tx_irq;
      r.rx_level = urb_pkg::LEVEL_W'(rx_wr - rx_rd);
      r.tx_level = urb_pkg::LEVEL_W'(tx_wr - tx_rd);
      return r;
    endfunction

    function void note_event(urb_pkg::in_item_t it);
      pending_results.push_back(ring_step(it));
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [urb_pkg::OUT_TDATA_W-1:0] beat);
      ring_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat %h arrived with nothing expected", beat);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp("read_data", e.read_data, beat[7:0]);
      cmp("read_valid", 8'(e.read_valid), 8'(beat[8]));
      cmp("write_accepted", 8'(e.write_accepted), 8'(beat[9]));
      cmp("rx_accepted", 8'(e.rx_accepted), 8'(beat[10]));
      cmp("tx_byte", e.tx_byte, beat[18:11]);
      cmp("tx_valid", 8'(e.tx_valid), 8'(beat[19]));
      cmp("tx_irq_enable", 8'(e.tx_irq_enable), 8'(beat[20]));
      cmp("clear_tx_done", 8'(e.clear_tx_done), 8'(beat[21]));
      cmp("rx_level", 8'(e.rx_level), 8'(beat[27:22]));
      cmp("tx_level", 8'(e.tx_level), 8'(beat[33:28]));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic                            cfg_wr_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [urb_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [urb_pkg::OP_W-1:0]        in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [urb_pkg::OUT_TDATA_W-1:0] out_tdata;

  ring_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int cycle_count;

  uart_rx_tx_ring_buffers_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // results are checked before the event of the same edge is noted
  always @(posedge clk) begin
    urb_pkg::in_item_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_beat(out_tdata);
      if (in_tvalid && in_tready) begin
        seen.op = urb_pkg::op_t'(in_tuser);
        seen.data = in_tdata[7:0];
        seen.frame_error = in_tdata[8];
        seen.overrun_error = in_tdata[9];
        seen.parity_error = in_tdata[10];
        sb.note_event(seen);
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic urb_pkg::in_item_t mk_event(urb_pkg::op_t op, logic [7:0] data,
                                                 logic fe, logic ovr, logic pe);
    urb_pkg::in_item_t it;
    it.op = op;
    it.data = data;
    it.frame_error = fe;
    it.overrun_error = ovr;
    it.parity_error = pe;
    return it;
  endfunction

  function automatic int pick_push_pct();
    case ($urandom_range(2))
      0: return 15;
      1: return 50;
      default: return 85;
    endcase
  endfunction

  // half the events go to each ring; push_pct steers that ring toward full or empty
  function automatic urb_pkg::in_item_t random_event(int rx_push_pct, int tx_push_pct);
    urb_pkg::in_item_t it;
    it.data = 8'($urandom_range(255));
    it.frame_error = ($urandom_range(99) < 5);
    it.overrun_error = ($urandom_range(99) < 5);
    it.parity_error = ($urandom_range(99) < 20);
    if ($urandom_range(1))
      it.op = ($urandom_range(99) < rx_push_pct) ? urb_pkg::OP_RX_BYTE : urb_pkg::OP_READ;
    else
      it.op = ($urandom_range(99) < tx_push_pct) ? urb_pkg::OP_WRITE : urb_pkg::OP_TX_READY;
    return it;
  endfunction

  task automatic send_event(input urb_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {5'b0, it.parity_error, it.overrun_error, it.frame_error, it.data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_empty(input int tail);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_parity_check(input logic value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.parity_on = value;
  endtask

  task automatic run_random(input int count);
    int left;
    int seg;
    int rx_pct;
    int tx_pct;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(100, 250);
      rx_pct = pick_push_pct();
      tx_pct = pick_push_pct();
      for (int i = 0; i < seg && left > 0; i++) begin
        send_event(random_event(rx_pct, tx_pct));
        left--;
      end
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    hold_request = 0;
    hold_left = 0;
    cycle_count = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_parity_check(1'b0);
    // empty rings, then push extreme bytes into both and drain them
    send_event(mk_event(urb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_WRITE, 8'hff, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'hff, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'h5a, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'ha5, 1'b0, 1'b1, 1'b0));
    // parity error passes while the check is off
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'h3c, 1'b0, 1'b0, 1'b1));
    repeat (4) send_event(mk_event(urb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0));
    wait_empty(3);

    write_parity_check(1'b1);
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'hc3, 1'b0, 1'b0, 1'b1));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'h81, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(urb_pkg::OP_RX_BYTE, 8'h7e, 1'b0, 1'b0, 1'b0));
    // status flags on other ops are don't-care
    send_event(mk_event(urb_pkg::OP_WRITE, 8'h55, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(urb_pkg::OP_TX_READY, 8'haa, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(urb_pkg::OP_READ, 8'hff, 1'b1, 1'b1, 1'b1));
    wait_empty(3);

    send_idle_pct = 38;
    recv_idle_pct = 80;
    hold_request = 150;
    run_random(510);
    wait_empty(3);

    write_parity_check(1'b0);
    send_idle_pct = 80;
    recv_idle_pct = 38;
    run_random(510);
    wait_empty(3);

    write_parity_check(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 200;
    run_random(250);
    // sender pauses until the ring unit has answered everything
    wait_empty(0);
    run_random(255);
    wait_empty(5);

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
